// ----- hw/rtl/sdorq_pkg.sv -----
package sdorq_pkg;

  localparam int unsigned SectorW           = 48;
  localparam int unsigned TagW              = 8;
  localparam int unsigned FillW             = 5;
  localparam int unsigned DefaultQueueDepth = 16;

  // item kinds
  localparam logic KindAdd      = 1'b0;
  localparam logic KindDispatch = 1'b1;

  typedef enum logic [1:0] {
    StAdded      = 2'd0,
    StDropped    = 2'd1,
    StDispatched = 2'd2,
    StEmpty      = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;     // capture the request fields, arm the walk
    logic    walk;     // advance the compare walk
    logic    up_init;  // arm a tail-to-slot shift that opens a hole
    logic    dn_init;  // arm a front pop shift
    logic    move;     // advance the armed shift
    logic    finish;   // update the count and present the result
    status_e code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_hit;
    logic walk_end;
    logic move_done;
  } stat_t;

endpackage

// ----- hw/rtl/sdorq_ctrl.sv -----
module sdorq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             kind_i,
  output logic             busy,
  input  sdorq_pkg::stat_t stat_i,
  output sdorq_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    Idle,
    Walk,
    ShInit,
    Shift,
    Insert,
    DnInit,
    DnMove,
    DnFin,
    Drop,
    Empty
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      Idle: begin
        if (start) begin
          if (kind_i == sdorq_pkg::KindDispatch) begin
            state_d = stat_i.empty ? Empty : DnInit;
          end else if (stat_i.full) begin
            state_d = Drop;
          end else begin
            state_d = stat_i.empty ? Insert : Walk;
          end
        end
      end
      Walk: begin
        priority if (stat_i.walk_hit) begin
          state_d = ShInit;
        end else if (stat_i.walk_end) begin
          state_d = Insert;
        end
      end
      ShInit: state_d = Shift;
      Shift: begin
        if (stat_i.move_done) begin
          state_d = Insert;
        end
      end
      DnInit: state_d = DnMove;
      DnMove: begin
        if (stat_i.move_done) begin
          state_d = DnFin;
        end
      end
      Insert, DnFin, Drop, Empty: state_d = Idle;
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != Idle);
    end
  end

  assign busy = busy_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.code    = sdorq_pkg::StAdded;
    cmd_o.load    = (state_q == Idle) && start;
    cmd_o.walk    = (state_q == Walk);
    cmd_o.up_init = (state_q == ShInit);
    cmd_o.dn_init = (state_q == DnInit);
    cmd_o.move    = (state_q == Shift) || (state_q == DnMove);
    unique case (state_q)
      Insert: begin
        cmd_o.finish = 1'b1;
        cmd_o.code   = sdorq_pkg::StAdded;
      end
      DnFin: begin
        cmd_o.finish = 1'b1;
        cmd_o.code   = sdorq_pkg::StDispatched;
      end
      Drop: begin
        cmd_o.finish = 1'b1;
        cmd_o.code   = sdorq_pkg::StDropped;
      end
      Empty: begin
        cmd_o.finish = 1'b1;
        cmd_o.code   = sdorq_pkg::StEmpty;
      end
      default: cmd_o.finish = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/sdorq_dpath.sv -----
module sdorq_dpath #(
  parameter int unsigned QueueDepth = sdorq_pkg::DefaultQueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdorq_pkg::cmd_t                cmd_i,
  output sdorq_pkg::stat_t               stat_o,
  input  logic [sdorq_pkg::SectorW-1:0]  req_sector_i,
  input  logic [sdorq_pkg::TagW-1:0]     req_tag_i,
  input  logic [sdorq_pkg::SectorW-1:0]  head_sector_i,
  output logic                           valid_o,
  output logic [1:0]                     status_o,
  output logic [sdorq_pkg::SectorW-1:0]  out_sector_o,
  output logic [sdorq_pkg::TagW-1:0]     out_tag_o,
  output logic [sdorq_pkg::FillW-1:0]    fill_o
);

  localparam int unsigned SW = sdorq_pkg::SectorW;
  localparam int unsigned TW = sdorq_pkg::TagW;
  localparam int unsigned FW = sdorq_pkg::FillW;
  localparam int unsigned EW = SW + TW;
  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  function automatic logic [SW-1:0] abs_diff(logic [SW-1:0] a, logic [SW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // entry storage: sector in the upper bits, tag in the lower bits
  logic [EW-1:0] mem_q [QueueDepth];
  logic [EW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wadr;
  logic [EW-1:0] mem_wdata;

  logic [CW-1:0] cnt_q, cnt_d, pos_q, mv_q;
  logic [AW-1:0] rd_q, wadr_q, i1_q, i2_q;
  logic          v1_q, v2_q, last2_q, wpend_q, cap_q, dir_up_q;
  logic [SW-1:0] sec_q, ref_q, dn_q, de_q, cap_sec_q;
  logic [TW-1:0] tag_q, cap_tag_q;
  logic          rd_live, closer, do_insert;
  logic [CW+FW-1:0] fill_ext;

  assign rd_live   = (CW'(rd_q) < cnt_q);
  assign closer    = (dn_q < de_q);
  assign do_insert = cmd_i.finish && (cmd_i.code == sdorq_pkg::StAdded);

  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.full      = (cnt_q == CW'(QueueDepth));
  assign stat_o.walk_hit  = v2_q && closer;
  assign stat_o.walk_end  = v2_q && !closer && last2_q;
  assign stat_o.move_done = (mv_q == '0) && !wpend_q;

  assign mem_we    = wpend_q || do_insert;
  assign mem_wadr  = wpend_q ? wadr_q : AW'(pos_q);
  assign mem_wdata = wpend_q ? rdata_q : {sec_q, tag_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wadr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_q];
  end

  always_comb begin
    unique case (cmd_i.code)
      sdorq_pkg::StAdded:      cnt_d = cnt_q + CW'(1);
      sdorq_pkg::StDispatched: cnt_d = cnt_q - CW'(1);
      default:                 cnt_d = cnt_q;
    endcase
  end

  assign fill_ext = {{FW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      mv_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      wpend_q <= 1'b0;
      cap_q   <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
      end
      if (cmd_i.walk) begin
        v1_q <= rd_live;
        v2_q <= v1_q;
      end
      if (cmd_i.up_init) begin
        mv_q    <= cnt_q - pos_q;
        wpend_q <= 1'b0;
        cap_q   <= 1'b0;
      end
      if (cmd_i.dn_init) begin
        mv_q    <= cnt_q;
        wpend_q <= 1'b0;
        cap_q   <= 1'b0;
      end
      if (cmd_i.move) begin
        if (mv_q != '0) begin
          mv_q    <= mv_q - CW'(1);
          // the front entry on a pop is reported, not moved
          wpend_q <= dir_up_q || (rd_q != '0);
          cap_q   <= !dir_up_q && (rd_q == '0);
        end else begin
          wpend_q <= 1'b0;
          cap_q   <= 1'b0;
        end
      end
      if (cmd_i.finish) begin
        cnt_q <= cnt_d;
      end
      valid_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sec_q <= req_sector_i;
      tag_q <= req_tag_i;
      ref_q <= head_sector_i;
      rd_q  <= '0;
      pos_q <= cnt_q;
    end
    if (cmd_i.walk) begin
      if (rd_live) begin
        i1_q <= rd_q;
        rd_q <= rd_q + AW'(1);
      end
      if (v1_q) begin
        dn_q    <= abs_diff(sec_q, ref_q);
        de_q    <= abs_diff(rdata_q[EW-1:TW], ref_q);
        ref_q   <= rdata_q[EW-1:TW];
        i2_q    <= i1_q;
        last2_q <= (CW'(i1_q) == (cnt_q - CW'(1)));
      end
      if (v2_q && closer) begin
        pos_q <= CW'(i2_q);
      end
    end
    if (cmd_i.up_init) begin
      rd_q     <= AW'(cnt_q - CW'(1));
      dir_up_q <= 1'b1;
    end
    if (cmd_i.dn_init) begin
      rd_q     <= '0;
      dir_up_q <= 1'b0;
    end
    if (cmd_i.move && (mv_q != '0)) begin
      rd_q   <= dir_up_q ? (rd_q - AW'(1)) : (rd_q + AW'(1));
      wadr_q <= dir_up_q ? (rd_q + AW'(1)) : (rd_q - AW'(1));
    end
    if (cap_q) begin
      cap_sec_q <= rdata_q[EW-1:TW];
      cap_tag_q <= rdata_q[TW-1:0];
    end
    if (cmd_i.finish) begin
      status_o <= cmd_i.code;
      fill_o   <= fill_ext[FW-1:0];
      if (cmd_i.code == sdorq_pkg::StDispatched) begin
        out_sector_o <= cap_sec_q;
        out_tag_o    <= cap_tag_q;
      end else begin
        out_sector_o <= '0;
        out_tag_o    <= '0;
      end
    end
  end

endmodule

// ----- hw/rtl/seek_distance_ordered_request_queue_top.sv -----
// Channel   Ports                                                      Transfer when
// -------   --------------------------------------------------------   -----------------
// request   start, kind_i, req_sector_i, req_tag_i, head_sector_i      start && !busy
// result    valid_o, status_o, out_sector_o, out_tag_o, fill_o         valid_o, one cycle
//
// One request is in flight at a time; busy holds from the accepting edge until the strobe.
// An add walks the queue comparing seek distances, opens a slot by shifting the tail up when
// it lands before the last entry, writes the entry and presents the result; a dispatch pops
// the front entry by shifting the rest down. A dropped add, an empty dispatch or an add to an
// empty queue answers without a walk or shift. The entry memory has a single read and write
// port. Reset clears count and control state only; no stalls.
module seek_distance_ordered_request_queue_top #(
  parameter int unsigned QueueDepth = sdorq_pkg::DefaultQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request transfer
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [sdorq_pkg::SectorW-1:0] req_sector_i,
  input  logic [sdorq_pkg::TagW-1:0]    req_tag_i,
  input  logic [sdorq_pkg::SectorW-1:0] head_sector_i,
  // result transfer
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [sdorq_pkg::SectorW-1:0] out_sector_o,
  output logic [sdorq_pkg::TagW-1:0]    out_tag_o,
  output logic [sdorq_pkg::FillW-1:0]   fill_o
);

  sdorq_pkg::cmd_t  cmd;
  sdorq_pkg::stat_t stat;

  // sequence the walk, the shift and the result
  sdorq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // hold the queue, compare seek distances, move entries
  sdorq_dpath #(
    .QueueDepth (QueueDepth)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_sector_i  (req_sector_i),
    .req_tag_i     (req_tag_i),
    .head_sector_i (head_sector_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .out_sector_o  (out_sector_o),
    .out_tag_o     (out_tag_o),
    .fill_o        (fill_o)
  );

endmodule
